/* hw/rtl/vcg_pkg.sv */
package vcg_pkg;

	// Default parameter values
	localparam int unsigned PermitSourcesDefault = 3;
	localparam int unsigned VelBitsDefault       = 16;

	// Fixed field widths
	localparam int unsigned ACTION_BITS = 3;
	localparam int unsigned SOURCE_BITS = 2;
	localparam int unsigned MODE_BITS   = 3;
	localparam int unsigned GATE_BITS   = 2;
	localparam int unsigned AGE_BITS    = 16;
	localparam int unsigned EPS_BITS    = 15;
	localparam int unsigned CFG_IDX_BITS  = 3;
	localparam int unsigned CFG_DATA_BITS = 16;

	// Event codes carried in the input tuser
	localparam logic [ACTION_BITS-1:0] ACT_TICK    = 3'd0;
	localparam logic [ACTION_BITS-1:0] ACT_COMMAND = 3'd1;
	localparam logic [ACTION_BITS-1:0] ACT_PERMIT  = 3'd2;
	localparam logic [ACTION_BITS-1:0] ACT_PARK    = 3'd3;
	localparam logic [ACTION_BITS-1:0] ACT_FORCE   = 3'd4;

	// Forced steering modes
	localparam logic [MODE_BITS-1:0] FMODE_AUTO      = 3'd0;
	localparam logic [MODE_BITS-1:0] FMODE_ACKERMANN = 3'd1;
	localparam logic [MODE_BITS-1:0] FMODE_CRAB      = 3'd2;
	localparam logic [MODE_BITS-1:0] FMODE_SIDESLIP  = 3'd3;
	localparam logic [MODE_BITS-1:0] FMODE_SPIN      = 3'd4;
	localparam logic [MODE_BITS-1:0] FMODE_PARK      = 3'd5;

	// Predicted steering modes
	localparam logic [MODE_BITS-1:0] PMODE_ACKERMANN = 3'd0;
	localparam logic [MODE_BITS-1:0] PMODE_CRAB      = 3'd1;
	localparam logic [MODE_BITS-1:0] PMODE_SPIN      = 3'd2;
	localparam logic [MODE_BITS-1:0] PMODE_SIDESLIP  = 3'd3;
	localparam logic [MODE_BITS-1:0] PMODE_PARK      = 3'd4;

	// Gate states
	localparam logic [GATE_BITS-1:0] GATE_OK      = 2'd0;
	localparam logic [GATE_BITS-1:0] GATE_PARK    = 2'd1;
	localparam logic [GATE_BITS-1:0] GATE_TIMEOUT = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_ALLOW_REVERSE   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LATERAL_ALLOWED = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CMD_TIMEOUT     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PERMIT_TIMEOUT  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_LINEAR_EPS      = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_LATERAL_EPS     = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_YAW_EPS         = 3'd6;

	// Configuration reset values
	localparam logic [AGE_BITS-1:0] CMD_TIMEOUT_RESET    = 16'd250;
	localparam logic [AGE_BITS-1:0] PERMIT_TIMEOUT_RESET = 16'd750;
	localparam logic [EPS_BITS-1:0] EPS_RESET            = 15'd20;

	// Saturating age increment
	function automatic logic [AGE_BITS-1:0] age_up(input logic [AGE_BITS-1:0] a);
		age_up = (a == {AGE_BITS{1'b1}}) ? a : a + 1'b1;
	endfunction

endpackage

/* hw/rtl/velocity_command_gate_core.sv */
// Velocity command gate. Events arrive on the slave stream, with the event code in s_tuser:
// a tick, a velocity command, a reverse permit update, a park flag or a forced steering mode.
// A new word can be accepted on every clock unless the slave side stalls; only a
// tick produces a result word, which appears on the master stream in the cycle after the tick is
// accepted and is held in a single output register. The slave side stalls only while that
// register holds a word the consumer has not yet taken. On a tick the command and permit ages
// are advanced (saturating) before the freshness tests, so a command is stale once more than
// cmd_timeout_ticks ticks have passed since it arrived. Park, from the flag or from the forced
// park mode, zeroes the output; otherwise a stale or absent command zeroes it. A negative
// forward speed is clamped to zero unless reverse is allowed globally or by a fresh permit,
// and a sideways speed at or above lateral_eps is clamped unless the lateral policy or a
// forced crab or side-slip mode allows it. Configuration registers are written through the
// cfg port and should only be changed while the block is idle.
module velocity_command_gate_core
	import vcg_pkg::*;
#(
	parameter int unsigned PERMIT_SOURCES = PermitSourcesDefault,
	parameter int unsigned VEL_BITS       = VelBitsDefault
) (
	input  logic clk,
	input  logic arst_n,

	// Configuration write port
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,

	// Event stream
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// From bit 0 up: vel_x, vel_y, yaw_rate, permit_source, flag, mode_code, zero padding
	input  logic [((3*VEL_BITS+6+7)/8)*8-1:0]       s_tdata,
	// action
	input  logic [ACTION_BITS-1:0]                  s_tuser,

	// Gated command stream
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// From bit 0 up: out_vel_x, out_vel_y, out_yaw_rate, steer_mode, has_command,
	// reverse_clamped, lateral_clamped, zero padding
	output logic [((3*VEL_BITS+6+7)/8)*8-1:0]       m_tdata,
	// gate_state
	output logic [GATE_BITS-1:0]                    m_tuser
);

	localparam int unsigned FIELD_BITS = 3*VEL_BITS + 6;
	localparam int unsigned TDATA_BITS = ((FIELD_BITS + 7) / 8) * 8;
	localparam int unsigned PAD_BITS   = TDATA_BITS - FIELD_BITS;
	// Width in which magnitudes and thresholds are compared.
	localparam int unsigned CMP_BITS   = (VEL_BITS > EPS_BITS) ? VEL_BITS : EPS_BITS;

	typedef logic signed [VEL_BITS-1:0] vel_t;

	typedef struct packed {
		logic                 lat_clamp;
		logic                 rev_clamp;
		logic                 has_cmd;
		logic [MODE_BITS-1:0] mode;
		vel_t                 wz;
		vel_t                 vy;
		vel_t                 vx;
	} result_t;

	// Magnitude of a velocity, widened for comparison against a threshold.
	function automatic logic [CMP_BITS-1:0] mag(input vel_t v);
		logic [VEL_BITS-1:0] m;
		m   = v[VEL_BITS-1] ? VEL_BITS'(-v) : VEL_BITS'(v);
		mag = CMP_BITS'(m);
	endfunction

	// Configuration registers
	logic                 allow_reverse_q;
	logic                 lateral_allowed_q;
	logic [AGE_BITS-1:0]  cmd_timeout_q;
	logic [AGE_BITS-1:0]  permit_timeout_q;
	logic [EPS_BITS-1:0]  linear_eps_q;
	logic [EPS_BITS-1:0]  lateral_eps_q;
	logic [EPS_BITS-1:0]  yaw_eps_q;

	// Gate state
	vel_t                 stored_vx_q;
	vel_t                 stored_vy_q;
	vel_t                 stored_wz_q;
	logic                 cmd_seen_q;
	logic [AGE_BITS-1:0]  cmd_age_q;
	logic                 park_q;
	logic [MODE_BITS-1:0] forced_mode_q;
	logic [PERMIT_SOURCES-1:0] permit_en_q;
	logic [PERMIT_SOURCES-1:0] permit_seen_q;
	logic [AGE_BITS-1:0]  permit_age_q [PERMIT_SOURCES];

	// Output register
	result_t              result_q;
	logic [GATE_BITS-1:0] gate_q;
	logic                 out_valid_q;

	// Unpacked input word
	vel_t                   in_vx, in_vy, in_wz;
	logic [SOURCE_BITS-1:0] in_src;
	logic                   in_flag;
	logic [MODE_BITS-1:0]   in_mode;

	assign in_vx   = s_tdata[VEL_BITS-1:0];
	assign in_vy   = s_tdata[2*VEL_BITS-1:VEL_BITS];
	assign in_wz   = s_tdata[3*VEL_BITS-1:2*VEL_BITS];
	assign in_src  = s_tdata[3*VEL_BITS+1:3*VEL_BITS];
	assign in_flag = s_tdata[3*VEL_BITS+2];
	assign in_mode = s_tdata[3*VEL_BITS+5:3*VEL_BITS+3];

	logic accept;
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	logic is_tick, is_cmd, is_permit, is_park, is_force;
	always_comb begin
		is_tick   = 1'b0;
		is_cmd    = 1'b0;
		is_permit = 1'b0;
		is_park   = 1'b0;
		is_force  = 1'b0;
		unique case (s_tuser)
			ACT_TICK:    is_tick   = 1'b1;
			ACT_COMMAND: is_cmd    = 1'b1;
			ACT_PERMIT:  is_permit = 1'b1;
			ACT_PARK:    is_park   = 1'b1;
			ACT_FORCE:   is_force  = 1'b1;
			default: ;
		endcase
	end

	// Aged values as seen by the tick that is being accepted.
	logic [AGE_BITS-1:0] cmd_age_nx;
	logic [AGE_BITS-1:0] permit_age_nx [PERMIT_SOURCES];
	logic                any_permit;

	always_comb begin
		cmd_age_nx = age_up(cmd_age_q);
		any_permit = 1'b0;
		for (int i = 0; i < PERMIT_SOURCES; i++) begin
			permit_age_nx[i] = age_up(permit_age_q[i]);
			if (permit_en_q[i] && permit_seen_q[i] && (permit_age_nx[i] <= permit_timeout_q))
				any_permit = 1'b1;
		end
	end

	// Gating of the stored command for one tick.
	result_t              result_d;
	logic [GATE_BITS-1:0] gate_d;
	logic                 vy_big, vx_small, wz_big, forced_lateral, fresh, parked;

	always_comb begin
		vy_big   = mag(stored_vy_q) >= CMP_BITS'(lateral_eps_q);
		vx_small = mag(stored_vx_q) <  CMP_BITS'(linear_eps_q);
		wz_big   = mag(stored_wz_q) >= CMP_BITS'(yaw_eps_q);
		forced_lateral = (forced_mode_q == FMODE_CRAB) || (forced_mode_q == FMODE_SIDESLIP);
		parked   = park_q || (forced_mode_q == FMODE_PARK);
		fresh    = cmd_seen_q && (cmd_age_nx <= cmd_timeout_q);

		result_d.vx        = '0;
		result_d.vy        = '0;
		result_d.wz        = '0;
		result_d.mode      = PMODE_ACKERMANN;
		result_d.has_cmd   = cmd_seen_q;
		result_d.rev_clamp = 1'b0;
		result_d.lat_clamp = 1'b0;
		gate_d             = GATE_OK;

		if (parked) begin
			result_d.mode = PMODE_PARK;
			gate_d        = GATE_PARK;
		end else if (!fresh) begin
			gate_d        = GATE_TIMEOUT;
		end else begin
			result_d.vx = stored_vx_q;
			result_d.vy = stored_vy_q;
			result_d.wz = stored_wz_q;
			if (vx_small && wz_big)
				result_d.mode = PMODE_SPIN;
			if (stored_vx_q[VEL_BITS-1] && !allow_reverse_q && !any_permit) begin
				result_d.vx        = '0;
				result_d.rev_clamp = 1'b1;
			end
			if (vy_big) begin
				if (!lateral_allowed_q && !forced_lateral) begin
					// Clamped sideways speed falls back to the mode seen from the stored
					// command, which is crab as the stored speed is above threshold.
					result_d.vy        = '0;
					result_d.lat_clamp = 1'b1;
					result_d.mode      = PMODE_CRAB;
				end else begin
					result_d.mode = (forced_mode_q == FMODE_SIDESLIP) ? PMODE_SIDESLIP
					                                                  : PMODE_CRAB;
				end
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_reverse_q   <= 1'b0;
			lateral_allowed_q <= 1'b0;
			cmd_timeout_q     <= CMD_TIMEOUT_RESET;
			permit_timeout_q  <= PERMIT_TIMEOUT_RESET;
			linear_eps_q      <= EPS_RESET;
			lateral_eps_q     <= EPS_RESET;
			yaw_eps_q         <= EPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALLOW_REVERSE:   allow_reverse_q   <= cfg_data[0];
				REG_LATERAL_ALLOWED: lateral_allowed_q <= cfg_data[0];
				REG_CMD_TIMEOUT:     cmd_timeout_q     <= cfg_data[AGE_BITS-1:0];
				REG_PERMIT_TIMEOUT:  permit_timeout_q  <= cfg_data[AGE_BITS-1:0];
				REG_LINEAR_EPS:      linear_eps_q      <= cfg_data[EPS_BITS-1:0];
				REG_LATERAL_EPS:     lateral_eps_q     <= cfg_data[EPS_BITS-1:0];
				REG_YAW_EPS:         yaw_eps_q         <= cfg_data[EPS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Gate state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_vx_q   <= '0;
			stored_vy_q   <= '0;
			stored_wz_q   <= '0;
			cmd_seen_q    <= 1'b0;
			cmd_age_q     <= '0;
			park_q        <= 1'b0;
			forced_mode_q <= FMODE_AUTO;
			permit_en_q   <= '0;
			permit_seen_q <= '0;
			for (int i = 0; i < PERMIT_SOURCES; i++)
				permit_age_q[i] <= '0;
		end else if (accept) begin
			if (is_tick) begin
				cmd_age_q <= cmd_age_nx;
				for (int i = 0; i < PERMIT_SOURCES; i++)
					permit_age_q[i] <= permit_age_nx[i];
			end
			if (is_cmd) begin
				stored_vx_q <= in_vx;
				stored_vy_q <= in_vy;
				stored_wz_q <= in_wz;
				cmd_seen_q  <= 1'b1;
				cmd_age_q   <= '0;
			end
			if (is_permit) begin
				// Sources beyond the configured count match no slot and are dropped.
				for (int i = 0; i < PERMIT_SOURCES; i++) begin
					if (32'(in_src) == i) begin
						permit_en_q[i]   <= in_flag;
						permit_seen_q[i] <= 1'b1;
						permit_age_q[i]  <= '0;
					end
				end
			end
			if (is_park)
				park_q <= in_flag;
			if (is_force && (in_mode <= FMODE_PARK))
				forced_mode_q <= in_mode;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= accept && is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_tick) begin
			result_q <= result_d;
			gate_q   <= gate_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = gate_q;
	generate
		if (PAD_BITS > 0) begin : g_pad
			assign m_tdata = {{PAD_BITS{1'b0}}, result_q};
		end else begin : g_nopad
			assign m_tdata = result_q;
		end
	endgenerate

endmodule
